// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port checker.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define SDR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SDR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sdr_pkg.sv =====
// Shared types and constants of the SD card SPI multi-block stream reader.
// Used by every module of the block; depends on nothing.
package sdr_pkg;

  // Data block size and the width that counts data plus two CRC bytes
  localparam int BLOCK_BYTES = 512;
  localparam int BYTE_CNT_W  = $clog2(BLOCK_BYTES + 2);

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Configuration register indexes
  localparam int          CFG_INDEX_W   = 2;
  localparam logic [1:0]  CFG_ATTEMPTS  = 2'd0;
  localparam logic [1:0]  CFG_WINDOW    = 2'd1;
  localparam logic [7:0]  ATTEMPTS_RESET = 8'd50;
  localparam logic [7:0]  WINDOW_RESET   = 8'd10;

  // Input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_REPLY = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_POLL   = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  // Finish status
  localparam logic [7:0] STATUS_OK       = 8'd0;
  localparam logic [7:0] STATUS_REJECTED = 8'd1;

  // Bus bytes
  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] BYTE_TOKEN  = 8'hFE;
  localparam logic [7:0] BYTE_CRC    = 8'h95;
  localparam logic [7:0] BYTE_R1_OK  = 8'h00;
  localparam logic [7:0] CMD_PREFIX  = 8'b0100_0000;
  localparam logic [7:0] CMD_READ_MULTI = 8'd18;
  localparam logic [7:0] CMD_STOP       = 8'd12;

  typedef struct packed {
    logic        operation;
    logic [31:0] start_address;
    logic [31:0] last_sector;
    logic [7:0]  reply_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload;
    logic       last;
  } out_item_t;

  // Word sequence the back end plays out for one input item
  typedef enum logic [2:0] {
    SEQ_POLL        = 3'd0,  // poll
    SEQ_ATTEMPT     = 3'd1,  // 0xFF, poll
    SEQ_CMD18       = 3'd2,  // CMD18 frame, poll
    SEQ_CMD12       = 3'd3,  // 0xFF, CMD12 frame, poll
    SEQ_SAMPLE_POLL = 3'd4,  // sample, poll
    SEQ_DONE        = 3'd5   // finish status
  } seq_op_t;

  typedef struct packed {
    seq_op_t     op;
    logic [31:0] arg;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cmdq_status_t;

endpackage

// ===== hw/rtl/sdr_front.sv =====
// Front end: config registers, transfer FSM, at most one command per item.
// Depends on sdr_pkg.
module sdr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  sdr_pkg::in_item_t           item,
  input  logic                        cfg_we,
  input  logic [sdr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                  cfg_data,
  output logic                        cmd_valid,
  output sdr_pkg::cmd_t               cmd
);
  import sdr_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_READY   = 7'b0000010,
    PH_R1_READ = 7'b0000100,
    PH_TOKEN   = 7'b0001000,
    PH_DATA    = 7'b0010000,
    PH_R1_STOP = 7'b0100000,
    PH_BUSY    = 7'b1000000
  } phase_t;

  phase_t                phase, phase_next;
  logic [31:0]           address_hold, address_hold_next;
  logic [31:0]           final_sector, final_sector_next;
  logic [31:0]           sector_counter, sector_counter_next;
  logic [BYTE_CNT_W-1:0] byte_counter, byte_counter_next;
  logic [7:0]            poll_counter, poll_counter_next;
  logic [7:0]            attempt_counter, attempt_counter_next;
  logic [7:0]            attempt_limit;
  logic [7:0]            response_window;

  logic [7:0]            r;
  logic [7:0]            poll_inc;
  logic [7:0]            attempt_inc;
  logic [BYTE_CNT_W-1:0] byte_inc;

  assign r           = item.reply_byte;
  assign poll_inc    = poll_counter + 8'd1;
  assign attempt_inc = attempt_counter + 8'd1;
  assign byte_inc    = byte_counter + BYTE_CNT_W'(1);

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_limit   <= ATTEMPTS_RESET;
      response_window <= WINDOW_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ATTEMPTS) attempt_limit <= cfg_data;
      if (cfg_index == CFG_WINDOW)   response_window <= cfg_data;
    end
  end

  // Step the transfer for one accepted item
  always_comb begin
    phase_next           = phase;
    address_hold_next    = address_hold;
    final_sector_next    = final_sector;
    sector_counter_next  = sector_counter;
    byte_counter_next    = byte_counter;
    poll_counter_next    = poll_counter;
    attempt_counter_next = attempt_counter;
    cmd_valid            = 1'b0;
    cmd.op               = SEQ_POLL;
    cmd.arg              = 32'd0;
    if (accept) begin
      if (item.operation == OP_START) begin
        address_hold_next    = item.start_address;
        final_sector_next    = item.last_sector;
        sector_counter_next  = 32'd0;
        byte_counter_next    = '0;
        poll_counter_next    = 8'd0;
        attempt_counter_next = 8'd0;
        phase_next           = PH_READY;
        cmd_valid            = 1'b1;
        cmd.op               = SEQ_ATTEMPT;
      end else begin
        unique case (phase)
          PH_IDLE: begin
            cmd_valid = 1'b0;
          end
          PH_READY: begin
            cmd_valid = 1'b1;
            if (r == BYTE_IDLE) begin
              cmd.op            = SEQ_CMD18;
              cmd.arg           = address_hold;
              poll_counter_next = 8'd0;
              phase_next        = PH_R1_READ;
            end
          end
          PH_R1_READ: begin
            cmd_valid = 1'b1;
            if (r == BYTE_R1_OK) begin
              sector_counter_next = 32'd0;
              phase_next          = PH_TOKEN;
            end else begin
              poll_counter_next = poll_inc;
              if (poll_inc >= response_window) begin
                attempt_counter_next = attempt_inc;
                if (attempt_inc >= attempt_limit) begin
                  cmd.op     = SEQ_DONE;
                  cmd.arg    = {24'd0, STATUS_REJECTED};
                  phase_next = PH_IDLE;
                end else begin
                  cmd.op     = SEQ_ATTEMPT;
                  phase_next = PH_READY;
                end
              end
            end
          end
          PH_TOKEN: begin
            cmd_valid = 1'b1;
            if (r == BYTE_TOKEN) begin
              byte_counter_next = '0;
              phase_next        = PH_DATA;
            end
          end
          PH_DATA: begin
            cmd_valid         = 1'b1;
            byte_counter_next = byte_inc;
            if (byte_inc < BYTE_CNT_W'(BLOCK_BYTES + 2)) begin
              // data bytes go out as samples, CRC bytes are only polled past
              if (byte_counter < BYTE_CNT_W'(BLOCK_BYTES)) begin
                cmd.op  = SEQ_SAMPLE_POLL;
                cmd.arg = {24'd0, r};
              end
            end else if (sector_counter == final_sector) begin
              cmd.op            = SEQ_CMD12;
              poll_counter_next = 8'd0;
              phase_next        = PH_R1_STOP;
            end else begin
              sector_counter_next = sector_counter + 32'd1;
              phase_next          = PH_TOKEN;
            end
          end
          PH_R1_STOP: begin
            cmd_valid = 1'b1;
            if (r == BYTE_R1_OK) begin
              phase_next = PH_BUSY;
            end else begin
              poll_counter_next = poll_inc;
              if (poll_inc >= response_window) phase_next = PH_BUSY;
            end
          end
          PH_BUSY: begin
            cmd_valid = 1'b1;
            if (r == BYTE_IDLE) begin
              cmd.op     = SEQ_DONE;
              cmd.arg    = {24'd0, STATUS_OK};
              phase_next = PH_IDLE;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Hold transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      address_hold    <= 32'd0;
      final_sector    <= 32'd0;
      sector_counter  <= 32'd0;
      byte_counter    <= '0;
      poll_counter    <= 8'd0;
      attempt_counter <= 8'd0;
    end else begin
      phase           <= phase_next;
      address_hold    <= address_hold_next;
      final_sector    <= final_sector_next;
      sector_counter  <= sector_counter_next;
      byte_counter    <= byte_counter_next;
      poll_counter    <= poll_counter_next;
      attempt_counter <= attempt_counter_next;
    end
  end

endmodule

// ===== hw/rtl/sdr_cmd_fifo.sv =====
// Short command queue between front and back; head always at entry zero.
// Depends on sdr_pkg.
module sdr_cmd_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  sdr_pkg::cmd_t         wr_data,
  input  logic                  rd_en,
  output sdr_pkg::cmd_t         head,
  output sdr_pkg::cmdq_status_t status
);
  import sdr_pkg::*;

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_CNT_W-1:0] count;
  logic [CMDQ_CNT_W-1:0] wr_slot;

  assign wr_slot      = count - CMDQ_CNT_W'(rd_en);
  assign head         = entries[0];
  assign status.full  = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign status.empty = (count == '0);

  // Track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + CMDQ_CNT_W'(wr_en) - CMDQ_CNT_W'(rd_en);
    end
  end

  // Shift down on read, write into the first free slot
  for (genvar i = 0; i < CMDQ_DEPTH; i++) begin : g_entry
    if (i < CMDQ_DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (wr_en && (wr_slot == CMDQ_CNT_W'(i))) begin
          entries[i] <= wr_data;
        end else if (rd_en) begin
          entries[i] <= entries[i+1];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (wr_en && (wr_slot == CMDQ_CNT_W'(i))) begin
          entries[i] <= wr_data;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/sdr_back.sv =====
// Back end: expands queued commands to words, one per cycle while popped.
// Depends on sdr_pkg.
module sdr_back (
  input  logic                  clk,
  input  logic                  rst,
  input  sdr_pkg::cmd_t         head,
  input  sdr_pkg::cmdq_status_t q_status,
  output logic                  q_pop,
  input  logic                  pop,
  output logic                  empty,
  output sdr_pkg::out_item_t    result
);
  import sdr_pkg::*;

  logic       out_valid;
  logic [2:0] idx;
  logic       load;
  out_item_t  word;

  // Pick the word at the current position of the head command
  always_comb begin
    word.kind    = KIND_POLL;
    word.payload = BYTE_IDLE;
    word.last    = 1'b0;
    unique case (head.op)
      SEQ_POLL: begin
        word.last = 1'b1;
      end
      SEQ_ATTEMPT: begin
        if (idx == 3'd0) word.kind = KIND_SEND;
        else             word.last = 1'b1;
      end
      SEQ_CMD18: begin
        word.kind = KIND_SEND;
        unique case (idx)
          3'd0:    word.payload = CMD_PREFIX | CMD_READ_MULTI;
          3'd1:    word.payload = head.arg[31:24];
          3'd2:    word.payload = head.arg[23:16];
          3'd3:    word.payload = head.arg[15:8];
          3'd4:    word.payload = head.arg[7:0];
          3'd5:    word.payload = BYTE_CRC;
          default: begin
            word.kind = KIND_POLL;
            word.last = 1'b1;
          end
        endcase
      end
      SEQ_CMD12: begin
        word.kind = KIND_SEND;
        unique case (idx)
          3'd0:    word.payload = BYTE_IDLE;
          3'd1:    word.payload = CMD_PREFIX | CMD_STOP;
          3'd2, 3'd3, 3'd4, 3'd5: word.payload = 8'd0;
          3'd6:    word.payload = BYTE_CRC;
          default: begin
            word.kind = KIND_POLL;
            word.last = 1'b1;
          end
        endcase
      end
      SEQ_SAMPLE_POLL: begin
        if (idx == 3'd0) begin
          word.kind    = KIND_SAMPLE;
          word.payload = head.arg[7:0];
        end else begin
          word.last = 1'b1;
        end
      end
      SEQ_DONE: begin
        word.kind    = KIND_DONE;
        word.payload = head.arg[7:0];
        word.last    = 1'b1;
      end
      default: begin
        word.last = 1'b1;
      end
    endcase
  end

  assign load  = !q_status.empty && (!out_valid || pop);
  assign q_pop = load && word.last;
  assign empty = !out_valid;

  // Advance position within the command
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= word.last ? 3'd0 : idx + 3'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (load) result <= word;
  end

endmodule

// ===== hw/rtl/sd_spi_multi_block_stream_reader_core.sv =====
// SD card SPI multi-block read, host side: one item accepted per cycle while
// the command queue has room; results leave one word per cycle while popped.
// Item commands pass the queue; words are registered before they show.
// Each item expands to 0 to 8 result words, played out by the back end, so
// sustained input rate is set by the word count of each item's sequence.
// Synchronous reset clears state, queue and output; limit 50, window 10.
module sd_spi_multi_block_stream_reader_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  sdr_pkg::in_item_t               item,
  output logic                            empty,
  input  logic                            pop,
  output sdr_pkg::out_item_t              result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sdr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);
  import sdr_pkg::*;

  logic         accept;
  logic         cmd_valid;
  cmd_t         cmd;
  cmd_t         head;
  cmdq_status_t q_status;
  logic         q_pop;

  assign cfg_ready = 1'b1;
  assign full      = q_status.full;
  assign accept    = push && !q_status.full;

  sdr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  sdr_cmd_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .rd_en   (q_pop),
    .head    (head),
    .status  (q_status)
  );

  sdr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule

// ===== hw/rtl/sdr_checker.sv =====
// Port-level checks of the stream reader, bound to the top level.
// Depends on sdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sdr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            push,
  input logic                            full,
  input sdr_pkg::in_item_t               item,
  input logic                            empty,
  input logic                            pop,
  input sdr_pkg::out_item_t              result,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [sdr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [7:0]                      cfg_data
);
  import sdr_pkg::*;

  logic start_taken;
  logic closing_word;
  logic sample_word;

  assign start_taken  = push && !full && (item.operation == OP_START);
  assign closing_word = !empty && (result.kind == KIND_POLL || result.kind == KIND_DONE);
  assign sample_word  = !empty && (result.kind == KIND_SAMPLE);

  // Reset leaves nothing queued and nothing shown
  `SDR_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (empty && !full), "reset left results")

  // A start always yields output after the command queue
  `SDR_ASSERT(a_start_shows, clk, rst, start_taken |-> ##2 !empty, "start gave no result")

  // Poll and finish words close a sequence, samples never do
  `SDR_ASSERT(a_last_kind, clk, rst, closing_word |-> result.last, "poll or finish not last")
  `SDR_ASSERT(a_sample_not_last, clk, rst, sample_word |-> !result.last, "sample marked last")

  // A stalled result holds
  `SDR_ASSERT(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(result)), "stalled result changed")

endmodule

bind sd_spi_multi_block_stream_reader_core sdr_checker u_checker (.*);

// ===== bench/sd_spi_multi_block_stream_reader_checker.sv =====
`timescale 1ns / 100ps
// Checker for the SD card SPI multi-block stream reader: predicts the host words
// that each accepted item causes and compares them with the words popped.
// Depends on sdr_pkg; instantiated beside the core by the testbench top.
module sd_spi_multi_block_stream_reader_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  sdr_pkg::in_item_t               item,
  input  logic                            empty,
  input  logic                            pop,
  input  sdr_pkg::out_item_t              result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sdr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import sdr_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef enum logic [2:0] {
    CARD_IDLE,
    CARD_READY,
    CARD_R1_READ,
    CARD_TOKEN,
    CARD_DATA,
    CARD_R1_STOP,
    CARD_BUSY
  } card_phase_t;

  // Predicted host state and register copies
  logic [7:0]            attempt_limit = ATTEMPTS_RESET;
  logic [7:0]            window_len = WINDOW_RESET;
  card_phase_t           card_phase = CARD_IDLE;
  logic [31:0]           addr_latch = '0;
  logic [31:0]           final_sector = '0;
  logic [31:0]           sector_num = '0;
  logic [BYTE_CNT_W-1:0] byte_num = '0;
  logic [7:0]            poll_num = '0;
  logic [7:0]            attempt_num = '0;

  out_item_t step_words[$];
  out_item_t words_due[$];
  int        mismatches = 0;

  function automatic void add_word(logic [1:0] kind, logic [7:0] payload);
    out_item_t w;
    w.kind = kind;
    w.payload = payload;
    w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  // Frame a command, optionally led by an idle byte, then poll for R1
  function automatic void send_command(logic lead, logic [7:0] cmd, logic [31:0] arg);
    if (lead) add_word(KIND_SEND, BYTE_IDLE);
    add_word(KIND_SEND, CMD_PREFIX | cmd);
    add_word(KIND_SEND, arg[31:24]);
    add_word(KIND_SEND, arg[23:16]);
    add_word(KIND_SEND, arg[15:8]);
    add_word(KIND_SEND, arg[7:0]);
    add_word(KIND_SEND, BYTE_CRC);
    poll_num = '0;
    add_word(KIND_POLL, BYTE_IDLE);
  endfunction

  function automatic void open_attempt();
    add_word(KIND_SEND, BYTE_IDLE);
    add_word(KIND_POLL, BYTE_IDLE);
    card_phase = CARD_READY;
  endfunction

  // Advance the host on one byte from the card
  function automatic void take_reply(logic [7:0] r);
    case (card_phase)
      CARD_READY: begin
        if (r == BYTE_IDLE) begin
          send_command(1'b0, CMD_READ_MULTI, addr_latch);
          card_phase = CARD_R1_READ;
        end else begin
          add_word(KIND_POLL, BYTE_IDLE);
        end
      end
      CARD_R1_READ: begin
        if (r == BYTE_R1_OK) begin
          sector_num = '0;
          card_phase = CARD_TOKEN;
          add_word(KIND_POLL, BYTE_IDLE);
        end else begin
          poll_num = poll_num + 8'd1;
          if (poll_num >= window_len) begin
            attempt_num = attempt_num + 8'd1;
            if (attempt_num >= attempt_limit) begin
              add_word(KIND_DONE, STATUS_REJECTED);
              card_phase = CARD_IDLE;
            end else begin
              open_attempt();
            end
          end else begin
            add_word(KIND_POLL, BYTE_IDLE);
          end
        end
      end
      CARD_TOKEN: begin
        if (r == BYTE_TOKEN) begin
          byte_num = '0;
          card_phase = CARD_DATA;
        end
        add_word(KIND_POLL, BYTE_IDLE);
      end
      CARD_DATA: begin
        // pass data bytes on, skip the two CRC bytes
        if (byte_num < BLOCK_BYTES) add_word(KIND_SAMPLE, r);
        byte_num = byte_num + BYTE_CNT_W'(1);
        if (byte_num < BLOCK_BYTES + 2) begin
          add_word(KIND_POLL, BYTE_IDLE);
        end else if (sector_num == final_sector) begin
          send_command(1'b1, CMD_STOP, 32'd0);
          card_phase = CARD_R1_STOP;
        end else begin
          sector_num = sector_num + 32'd1;
          card_phase = CARD_TOKEN;
          add_word(KIND_POLL, BYTE_IDLE);
        end
      end
      CARD_R1_STOP: begin
        // a stop response that never comes still moves on once the window ends
        if (r == BYTE_R1_OK) begin
          card_phase = CARD_BUSY;
        end else begin
          poll_num = poll_num + 8'd1;
          if (poll_num >= window_len) card_phase = CARD_BUSY;
        end
        add_word(KIND_POLL, BYTE_IDLE);
      end
      CARD_BUSY: begin
        if (r == BYTE_IDLE) begin
          add_word(KIND_DONE, STATUS_OK);
          card_phase = CARD_IDLE;
        end else begin
          add_word(KIND_POLL, BYTE_IDLE);
        end
      end
      default: card_phase = CARD_IDLE;
    endcase
  endfunction

  // Queue the words one accepted item causes, marking the final one
  function automatic void queue_host_words(in_item_t it);
    out_item_t w;
    step_words.delete();
    if (it.operation == OP_START) begin
      addr_latch = it.start_address;
      final_sector = it.last_sector;
      sector_num = '0;
      byte_num = '0;
      poll_num = '0;
      attempt_num = '0;
      open_attempt();
    end else if (card_phase != CARD_IDLE) begin
      take_reply(it.reply_byte);
    end
    if (step_words.size() > 0) begin
      w = step_words.pop_back();
      w.last = 1'b1;
      step_words.push_back(w);
    end
    foreach (step_words[i]) words_due.push_back(step_words[i]);
  endfunction

  // Track registers, check popped words, predict pushed words
  always @(posedge clk) begin : compare
    out_item_t want;
    if (rst) begin
      attempt_limit = ATTEMPTS_RESET;
      window_len = WINDOW_RESET;
      card_phase = CARD_IDLE;
      addr_latch = '0;
      final_sector = '0;
      sector_num = '0;
      byte_num = '0;
      poll_num = '0;
      attempt_num = '0;
      words_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ATTEMPTS) attempt_limit = cfg_data;
        else if (cfg_index == CFG_WINDOW) window_len = cfg_data;
      end
      if (pop && !empty) begin
        if (words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected word: kind %0d payload %02h last %0d",
                     result.kind, result.payload, result.last);
        end else begin
          want = words_due.pop_front();
          if (result.kind !== want.kind || result.payload !== want.payload ||
              result.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("word mismatch: expected kind %0d payload %02h last %0d, got kind %0d payload %02h last %0d",
                       want.kind, want.payload, want.last,
                       result.kind, result.payload, result.last);
          end
        end
      end
      if (push && !full) queue_host_words(item);
    end
    fail_count <= mismatches;
    pending <= words_due.size();
  end

endmodule

// ===== bench/sd_spi_multi_block_stream_reader_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the SD card SPI multi-block stream reader core: plays the
// card side of multi-block reads over several register settings.
// Depends on sdr_pkg, the core and sd_spi_multi_block_stream_reader_checker.
module sd_spi_multi_block_stream_reader_core_tb;
  import sdr_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 45;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  in_item_t               item = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  out_item_t              result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;
  int                     fail_count;
  int                     pending;

  logic steady = 1'b0;
  int   hold_requests = 0;
  int   cycle_count = 0;
  int   phase_items = 0;
  int   lim_eff = int'(ATTEMPTS_RESET);
  int   win_eff = int'(WINDOW_RESET);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sd_spi_multi_block_stream_reader_core u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sd_spi_multi_block_stream_reader_checker u_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Pop words at random; hold off for a long stretch on request
  initial begin : result_side
    int seen;
    seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen) begin
        seen = hold_requests;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= steady || ($urandom_range(99) >= 28);
      end
    end
  end

  function automatic logic [7:0] byte_except(logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == avoid) b = b ^ 8'h01;
    return b;
  endfunction

  // Random byte leaning toward the bytes the host reacts to
  function automatic logic [7:0] lively_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if ($urandom_range(2) == 0) b = BYTE_IDLE;
    else if ($urandom_range(2) == 0) b = BYTE_R1_OK;
    else if ($urandom_range(2) == 0) b = BYTE_TOKEN;
    return b;
  endfunction

  // Offer one word after a random gap; return once it is taken
  task automatic offer(in_item_t it);
    while (!steady && $urandom_range(99) < 28) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    phase_items++;
  endtask

  task automatic card_reply(logic [7:0] b);
    in_item_t it;
    it.operation = OP_REPLY;
    it.start_address = $urandom;
    it.last_sector = $urandom;
    it.reply_byte = b;
    offer(it);
  endtask

  task automatic open_read(logic [31:0] addr, logic [31:0] last_sec);
    in_item_t it;
    it.operation = OP_START;
    it.start_address = addr;
    it.last_sector = last_sec;
    it.reply_byte = 8'($urandom_range(255));
    offer(it);
  endtask

  task automatic card_ready();
    repeat ($urandom_range(2)) card_reply(byte_except(BYTE_IDLE));
    card_reply(BYTE_IDLE);
  endtask

  // Answer R1 with a few misses, staying inside the window
  task automatic card_accept();
    int misses;
    misses = $urandom_range((win_eff > 4) ? 3 : win_eff - 1);
    repeat (misses) card_reply(byte_except(BYTE_R1_OK));
    card_reply(BYTE_R1_OK);
  endtask

  task automatic card_token();
    repeat ($urandom_range(3)) card_reply(byte_except(BYTE_TOKEN));
    card_reply(BYTE_TOKEN);
  endtask

  // Whole read through the stop command; silent_stop lets the stop window run out
  task automatic full_read(int last_sec, bit hold_off, bit silent_stop);
    open_read($urandom, last_sec);
    card_ready();
    card_accept();
    if (hold_off) hold_requests <= hold_requests + 1;
    for (int s = 0; s <= last_sec; s++) begin
      card_token();
      repeat (BLOCK_BYTES + 2) card_reply(8'($urandom_range(255)));
    end
    if (silent_stop) begin
      repeat (win_eff) card_reply(byte_except(BYTE_R1_OK));
    end else begin
      card_accept();
    end
    repeat ($urandom_range(4)) card_reply(byte_except(BYTE_IDLE));
    card_reply(BYTE_IDLE);
  endtask

  // Let every attempt miss its window until the host gives up
  task automatic rejected_read();
    open_read($urandom, $urandom);
    repeat (lim_eff) begin
      card_ready();
      repeat (win_eff) card_reply(byte_except(BYTE_R1_OK));
    end
  endtask

  // Get into the data phase, then leave it for the next start to abandon
  task automatic partial_read();
    open_read($urandom, $urandom);
    card_ready();
    card_accept();
    card_token();
    repeat ($urandom_range(20)) card_reply(8'($urandom_range(255)));
  endtask

  task automatic broken_read();
    open_read($urandom, $urandom);
    repeat ($urandom_range(6, 1)) card_reply(lively_byte());
  endtask

  // Stray replies; they do not count as stimulus
  task automatic line_noise();
    int keep;
    keep = phase_items;
    repeat ($urandom_range(4, 1)) card_reply(lively_byte());
    phase_items = keep;
  endtask

  task automatic run_sessions();
    int pick;
    while (phase_items < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 15 && lim_eff * (win_eff + 3) <= 120) rejected_read();
      else if (pick < 60) partial_read();
      else if (pick < 85) broken_read();
      else line_noise();
    end
  endtask

  // Stop offering and wait until every predicted word is out
  task automatic drain_all();
    push <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(logic [7:0] attempts, logic [7:0] window);
    write_reg(CFG_ATTEMPTS, attempts);
    write_reg(CFG_WINDOW, window);
    lim_eff = (attempts == 8'd0) ? 1 : int'(attempts);
    win_eff = (window == 8'd0) ? 1 : int'(window);
    phase_items = 0;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: replies while idle, largest sector count, restart while busy
    card_reply(BYTE_R1_OK);
    card_reply(BYTE_IDLE);
    open_read(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    card_reply(BYTE_R1_OK);
    card_reply(BYTE_IDLE);
    card_reply(8'h01);
    open_read(32'h0000_0000, 32'h0000_0000);
    card_reply(BYTE_IDLE);
    card_reply(BYTE_R1_OK);
    card_reply(BYTE_R1_OK);
    card_reply(BYTE_TOKEN);
    card_reply(8'h00);
    card_reply(8'hFF);
    card_reply(8'h80);
    card_reply(8'h7F);
    open_read($urandom, 32'h0000_0001);
    drain_all();

    // Widest settings; receiver holds off during a two-sector read
    set_limits(8'd255, 8'd255);
    full_read(1, 1'b1, 1'b0);
    run_sessions();
    drain_all();

    // Narrowest legal settings; stop response never arrives
    set_limits(8'd1, 8'd1);
    full_read(0, 1'b0, 1'b1);
    run_sessions();
    drain_all();

    // Zero settings act as one
    set_limits(8'd0, 8'd0);
    run_sessions();
    drain_all();

    // No idling on either side
    set_limits(8'd3, 8'd4);
    steady <= 1'b1;
    full_read(0, 1'b0, 1'($urandom_range(1)));
    run_sessions();
    drain_all();
    steady <= 1'b0;

    // Random settings, one from the full range and one narrow
    set_limits(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)));
    run_sessions();
    drain_all();
    set_limits(8'($urandom_range(6, 1)), 8'($urandom_range(6, 1)));
    run_sessions();
    drain_all();

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
